// ===== rtl/fpb_pkg.sv =====
// fpb_pkg: shared constants and types for the flash page buffer device
`default_nettype none
package fpb_pkg;
	localparam int NUM_BLOCKS = 4;
	localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int MAIN_AW = BLK_W + 17;
	localparam int SPR_AW  = BLK_W + 12;
	localparam int BUF_AW  = 16;
	localparam int SRAM_AW = 6;
	localparam int MIR_AW  = 7;
	localparam int CNT_W   = 18;

	localparam logic [1:0] F_RD_HW = 2'd0;
	localparam logic [1:0] F_WR_HW = 2'd1;
	localparam logic [1:0] F_RD_B  = 2'd2;
	localparam logic [1:0] F_WR_B  = 2'd3;

	localparam logic [7:0] C_LOAD0   = 8'h00;
	localparam logic [7:0] C_LOAD    = 8'h13;
	localparam logic [7:0] C_PROG_SP = 8'h1A;
	localparam logic [7:0] C_PROG    = 8'h80;
	localparam logic [7:0] C_ERASE   = 8'h94;
	localparam logic [7:0] C_UNLOCK  = 8'h23;
	localparam logic [7:0] C_NOP     = 8'hF0;

	localparam logic [15:0] IRQ_LOAD   = 16'h8080;
	localparam logic [15:0] IRQ_PROG   = 16'h8040;
	localparam logic [15:0] IRQ_ERASE  = 16'h8020;
	localparam logic [15:0] IRQ_UNLOCK = 16'h8000;
	localparam logic [15:0] IRQ_NOP    = 16'h8010;
	localparam logic [15:0] STAT_FAIL  = 16'h0400;

	localparam logic [15:0] BSEL_RST = 16'h0800;
	localparam logic [15:0] SYS_RST  = 16'h40C0;
	localparam logic [15:0] IRQ_RST  = 16'h8080;

	localparam logic [15:0] ID_MAKER  = 16'h00EC;
	localparam logic [15:0] ID_DEVICE = 16'h0035;
	localparam logic [15:0] ID_BUFSZ  = 16'h0800;
	localparam logic [15:0] ID_BOOTS  = 16'h0200;
	localparam logic [15:0] ID_AMOUNT = 16'h0201;
	localparam logic [15:0] PROT_OPEN = 16'h0004;
	localparam logic [15:0] PROT_LOCK = 16'h0002;

	localparam logic [5:0]  REG_HI   = 6'h3C;
	localparam logic [6:0]  AREG_WIN = 7'h20;
	localparam logic [17:0] ZERO_A   = 18'h3FC00;
	localparam logic [17:0] ZERO_B   = 18'h3FC02;
	localparam logic [10:0] SPR_HI   = 11'h400;
	localparam logic [9:0]  MIR_HI   = 10'h3FF;

	localparam logic [11:0] R_MAKER  = 12'h000;
	localparam logic [11:0] R_DEVICE = 12'h004;
	localparam logic [11:0] R_VER    = 12'h008;
	localparam logic [11:0] R_BUFSZ  = 12'h00C;
	localparam logic [11:0] R_BOOTS  = 12'h010;
	localparam logic [11:0] R_AMOUNT = 12'h014;
	localparam logic [11:0] R_TECH   = 12'h018;
	localparam logic [11:0] R_BSEL   = 12'h800;
	localparam logic [11:0] R_CMD    = 12'h880;
	localparam logic [11:0] R_SYSCFG = 12'h884;
	localparam logic [11:0] R_STAT   = 12'h900;
	localparam logic [11:0] R_IRQ    = 12'h904;
	localparam logic [11:0] R_UFIRST = 12'h930;
	localparam logic [11:0] R_ULAST  = 12'h934;
	localparam logic [11:0] R_PROT   = 12'h938;
	localparam logic [11:0] HI_HALF  = 12'h002;

	localparam logic [11:0] BSEL_ALT = 12'hC00;
	localparam logic [15:0] BUF_A    = 16'h0400;
	localparam logic [15:0] BUF_B    = 16'h0C00;

	localparam logic [CNT_W-1:0] LEN_PAGE  = 18'd2048;
	localparam logic [CNT_W-1:0] LEN_SPARE = 18'd64;
	localparam logic [CNT_W-1:0] LEN_BLOCK = 18'd131072;
	localparam logic [CNT_W-1:0] LEN_BSPR  = 18'd4096;

	typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_ACC, ST_SWEEP, ST_DONE} state_t;
	typedef enum logic [1:0] {OP_LOAD, OP_PROG_SP, OP_PROG, OP_ERASE} op_t;
endpackage
`default_nettype wire

// ===== rtl/fpb_if.sv =====
// fpb_if: request and response channel interfaces
`default_nettype none
interface fpb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [18:0] offset;
	logic [15:0] wdata;
	modport source(output valid, func, offset, wdata, input ready);
	modport sink(input valid, func, offset, wdata, output ready);
endinterface

interface fpb_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] rdata;
	logic        fault;
	modport source(output valid, rdata, fault, input ready);
	modport sink(input valid, rdata, fault, output ready);
endinterface
`default_nettype wire

// ===== rtl/fpb_ram.sv =====
// fpb_ram: generic simple dual-port RAM with registered read
`default_nettype none
module fpb_ram #(
	parameter int W = 16,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/flash_page_buffer_device.sv =====
// flash_page_buffer_device: memory-mapped flash with page buffer RAM, top level
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, offset, wdata
//   rsp      out  valid/ready    rdata, fault
//
// RAM and register accesses pass through accept, RAM read/decode and result register.
// Page load and main program walk 2048 words, spare program 64, erase 131072
// words of the block.
// After reset every array is swept to ones over 2**(BLK_W+17) addresses (524288 at four
// blocks), during which req.ready stays low.
// A finished word waits in the output register; the next request is taken meanwhile.
`default_nettype none
module flash_page_buffer_device (
	input  wire logic clk,
	input  wire logic arst_n,
	fpb_req_if.sink   req,
	fpb_rsp_if.source rsp
);
	localparam int BW = fpb_pkg::BLK_W;
	localparam int MAW = fpb_pkg::MAIN_AW;
	localparam int SAW = fpb_pkg::SPR_AW;

	fpb_pkg::state_t state_q, state_d;
	fpb_pkg::op_t    op_q;

	logic [1:0]  func_q;
	logic [17:0] a_q;
	logic [15:0] wd_q;

	logic [15:0] areg_q [8];
	logic [15:0] bsel_q, sys_q, stat_q, irq_q, ufirst_q, ulast_q;
	logic [7:0]  lastcmd_q;
	logic [fpb_pkg::NUM_BLOCKS-1:0] open_q;

	logic [MAW-1:0]             clr_q;
	logic [fpb_pkg::CNT_W-1:0]  cnt_q;
	logic                       v_s1;
	logic [16:0]                idx_s1;
	logic [BW+5:0]              page_q;
	logic [15:0]                bufb_q;
	logic                       lok_q;
	logic [15:0]                res_rd_q;
	logic                       res_flt_q;
	logic                       ov_q;
	logic [15:0]                ord_q;
	logic                       oflt_q;

	// RAM ports
	logic             buf_we, sr_we, mir_we, main_we, spa_we;
	logic [15:0]      buf_wa, buf_ra, buf_wd, buf_rd;
	logic [5:0]       sr_wa, sr_ra;
	logic [15:0]      sr_wd, sr_rd;
	logic [6:0]       mir_wa, mir_ra;
	logic [15:0]      mir_wd, mir_rd;
	logic [MAW-1:0]   main_wa, main_ra;
	logic [15:0]      main_wd, main_rd;
	logic [SAW-1:0]   spa_wa, spa_ra;
	logic [15:0]      spa_wd, spa_rd;

	// access decode
	logic        is_buf, is_spr, is_mir, slot;
	logic [17:0] ra;
	logic [15:0] rv, ram_hw, merged, cmp_rd;
	logic        rok, wok, cmp_flt;
	logic [7:0]  cmd;
	logic        cmd_known, blk_ex, blk_ok, unl_ok, cmd_ok;
	logic [15:0] done_code;
	logic        go_sweep;
	fpb_pkg::op_t sweep_op;
	logic [fpb_pkg::CNT_W-1:0] len;
	logic        issuing;
	logic        reg_wr;

	assign is_buf = !a_q[17];
	assign is_spr = (a_q[17:7] == fpb_pkg::SPR_HI);
	assign is_mir = (a_q[17:8] == fpb_pkg::MIR_HI);
	assign slot   = is_buf || is_spr || is_mir;
	assign ra     = func_q[1] ? {a_q[17:1], 1'b0} : a_q;

	assign blk_ex = (areg_q[0] < 16'(fpb_pkg::NUM_BLOCKS));
	assign blk_ok = blk_ex && open_q[areg_q[0][BW-1:0]];
	assign unl_ok = (ufirst_q <= ulast_q) && (ulast_q < 16'(fpb_pkg::NUM_BLOCKS));
	assign cmd    = wd_q[7:0];

	always_comb begin
		rv  = '0;
		rok = 1'b0;
		if (ra == fpb_pkg::ZERO_A || ra == fpb_pkg::ZERO_B) begin
			rok = 1'b1;
		end else if (ra[17:12] == fpb_pkg::REG_HI) begin
			if (ra[11:5] == fpb_pkg::AREG_WIN) begin
				rv  = areg_q[ra[4:2]];
				rok = !ra[0];
			end else begin
				rok = 1'b1;
				case (ra[11:0])
					fpb_pkg::R_MAKER, fpb_pkg::R_MAKER + fpb_pkg::HI_HALF: rv = fpb_pkg::ID_MAKER;
					fpb_pkg::R_DEVICE, fpb_pkg::R_DEVICE + fpb_pkg::HI_HALF: rv = fpb_pkg::ID_DEVICE;
					fpb_pkg::R_BUFSZ, fpb_pkg::R_BUFSZ + fpb_pkg::HI_HALF: rv = fpb_pkg::ID_BUFSZ;
					fpb_pkg::R_BOOTS, fpb_pkg::R_BOOTS + fpb_pkg::HI_HALF: rv = fpb_pkg::ID_BOOTS;
					fpb_pkg::R_AMOUNT, fpb_pkg::R_AMOUNT + fpb_pkg::HI_HALF: rv = fpb_pkg::ID_AMOUNT;
					fpb_pkg::R_TECH, fpb_pkg::R_TECH + fpb_pkg::HI_HALF: rv = '0;
					fpb_pkg::R_BSEL, fpb_pkg::R_BSEL + fpb_pkg::HI_HALF: rv = bsel_q;
					fpb_pkg::R_CMD, fpb_pkg::R_CMD + fpb_pkg::HI_HALF: rv = {8'h00, lastcmd_q};
					fpb_pkg::R_SYSCFG, fpb_pkg::R_SYSCFG + fpb_pkg::HI_HALF: rv = sys_q;
					fpb_pkg::R_STAT, fpb_pkg::R_STAT + fpb_pkg::HI_HALF: rv = stat_q;
					fpb_pkg::R_IRQ, fpb_pkg::R_IRQ + fpb_pkg::HI_HALF: rv = irq_q;
					fpb_pkg::R_UFIRST, fpb_pkg::R_UFIRST + fpb_pkg::HI_HALF: rv = ufirst_q;
					fpb_pkg::R_ULAST, fpb_pkg::R_ULAST + fpb_pkg::HI_HALF: rv = ulast_q;
					fpb_pkg::R_PROT, fpb_pkg::R_PROT + fpb_pkg::HI_HALF: begin
						rv = (ufirst_q < 16'(fpb_pkg::NUM_BLOCKS) && open_q[ufirst_q[BW-1:0]])
							? fpb_pkg::PROT_OPEN : fpb_pkg::PROT_LOCK;
					end
					default: rok = 1'b0;
				endcase
			end
		end
	end

	always_comb begin
		cmd_known = 1'b1;
		cmd_ok    = 1'b1;
		done_code = fpb_pkg::IRQ_NOP;
		go_sweep  = 1'b0;
		sweep_op  = fpb_pkg::OP_LOAD;
		case (cmd)
			fpb_pkg::C_LOAD0, fpb_pkg::C_LOAD: begin
				cmd_ok = blk_ex;
				done_code = fpb_pkg::IRQ_LOAD;
				go_sweep = 1'b1;
			end
			fpb_pkg::C_PROG_SP: begin
				cmd_ok = blk_ok;
				done_code = fpb_pkg::IRQ_PROG;
				go_sweep = blk_ok;
				sweep_op = fpb_pkg::OP_PROG_SP;
			end
			fpb_pkg::C_PROG: begin
				cmd_ok = blk_ok;
				done_code = fpb_pkg::IRQ_PROG;
				go_sweep = blk_ok;
				sweep_op = fpb_pkg::OP_PROG;
			end
			fpb_pkg::C_ERASE: begin
				cmd_ok = blk_ok;
				done_code = fpb_pkg::IRQ_ERASE;
				go_sweep = blk_ok;
				sweep_op = fpb_pkg::OP_ERASE;
			end
			fpb_pkg::C_UNLOCK: begin
				cmd_ok = unl_ok;
				done_code = fpb_pkg::IRQ_UNLOCK;
			end
			fpb_pkg::C_NOP: done_code = fpb_pkg::IRQ_NOP;
			default: cmd_known = 1'b0;
		endcase
	end

	always_comb begin
		wok = 1'b0;
		if (a_q[17:12] == fpb_pkg::REG_HI) begin
			if (a_q[11:5] == fpb_pkg::AREG_WIN) begin
				wok = !a_q[0];
			end else begin
				case (a_q[11:0])
					fpb_pkg::R_BSEL, fpb_pkg::R_SYSCFG, fpb_pkg::R_IRQ,
					fpb_pkg::R_UFIRST, fpb_pkg::R_ULAST: wok = 1'b1;
					fpb_pkg::R_CMD: wok = cmd_known;
					fpb_pkg::R_MAKER + fpb_pkg::HI_HALF, fpb_pkg::R_DEVICE + fpb_pkg::HI_HALF,
					fpb_pkg::R_VER + fpb_pkg::HI_HALF, fpb_pkg::R_BUFSZ + fpb_pkg::HI_HALF,
					fpb_pkg::R_BOOTS + fpb_pkg::HI_HALF, fpb_pkg::R_TECH + fpb_pkg::HI_HALF,
					fpb_pkg::R_BSEL + fpb_pkg::HI_HALF, fpb_pkg::R_CMD + fpb_pkg::HI_HALF,
					fpb_pkg::R_SYSCFG + fpb_pkg::HI_HALF, fpb_pkg::R_IRQ + fpb_pkg::HI_HALF,
					fpb_pkg::R_UFIRST + fpb_pkg::HI_HALF,
					fpb_pkg::R_ULAST + fpb_pkg::HI_HALF: wok = 1'b1;
					default: wok = 1'b0;
				endcase
			end
		end
	end

	assign reg_wr = (state_q == fpb_pkg::ST_ACC) && (func_q == fpb_pkg::F_WR_HW) && !slot && wok;

	assign ram_hw = is_buf ? buf_rd : (is_spr ? sr_rd : mir_rd);
	assign merged = a_q[0] ? {wd_q[7:0], ram_hw[7:0]} : {ram_hw[15:8], wd_q[7:0]};

	always_comb begin
		cmp_rd  = '0;
		cmp_flt = 1'b0;
		case (func_q)
			fpb_pkg::F_RD_HW: begin
				cmp_rd  = slot ? ram_hw : (rok ? rv : 16'h0000);
				cmp_flt = !slot && !rok;
			end
			fpb_pkg::F_WR_HW: cmp_flt = !slot && !wok;
			fpb_pkg::F_RD_B: begin
				if (slot) begin
					cmp_rd = {8'h00, a_q[0] ? ram_hw[15:8] : ram_hw[7:0]};
				end else if (rok) begin
					cmp_rd = {8'h00, a_q[0] ? rv[15:8] : rv[7:0]};
				end
				cmp_flt = !slot && !rok;
			end
			default: cmp_flt = !slot;
		endcase
	end

	always_comb begin
		case (op_q)
			fpb_pkg::OP_PROG_SP: len = fpb_pkg::LEN_SPARE;
			fpb_pkg::OP_ERASE:   len = fpb_pkg::LEN_BLOCK;
			default:             len = fpb_pkg::LEN_PAGE;
		endcase
	end
	assign issuing = (state_q == fpb_pkg::ST_SWEEP) && (cnt_q < len);

	// next state
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			fpb_pkg::ST_CLR: begin
				if (&clr_q) begin
					state_d = fpb_pkg::ST_IDLE;
				end
			end
			fpb_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = fpb_pkg::ST_ACC;
				end
			end
			fpb_pkg::ST_ACC: begin
				if (reg_wr && a_q[11:0] == fpb_pkg::R_CMD && go_sweep) begin
					state_d = fpb_pkg::ST_SWEEP;
				end else begin
					state_d = fpb_pkg::ST_DONE;
				end
			end
			fpb_pkg::ST_SWEEP: begin
				if (!issuing && !v_s1) begin
					state_d = fpb_pkg::ST_DONE;
				end
			end
			fpb_pkg::ST_DONE: begin
				if (!ov_q || rsp.ready) begin
					state_d = fpb_pkg::ST_IDLE;
				end
			end
			default: state_d = fpb_pkg::ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpb_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// RAM port steering
	always_comb begin
		buf_ra  = (state_q == fpb_pkg::ST_IDLE) ? req.offset[16:1]
			: bufb_q + {5'b0, cnt_q[10:0]};
		sr_ra   = (state_q == fpb_pkg::ST_IDLE) ? req.offset[6:1] : cnt_q[5:0];
		mir_ra  = req.offset[7:1];
		main_ra = {page_q, cnt_q[10:0]};
		spa_ra  = {page_q, cnt_q[5:0]};

		buf_we = 1'b0; buf_wa = a_q[16:1];                   buf_wd = wd_q;
		sr_we  = 1'b0; sr_wa  = a_q[6:1];                    sr_wd  = wd_q;
		mir_we = 1'b0; mir_wa = a_q[7:1];                    mir_wd = wd_q;
		main_we = 1'b0; main_wa = {page_q, idx_s1[10:0]};    main_wd = '1;
		spa_we  = 1'b0; spa_wa  = {page_q, idx_s1[5:0]};     spa_wd  = '1;

		case (state_q)
			fpb_pkg::ST_CLR: begin
				buf_we = 1'b1;  buf_wa = clr_q[15:0];          buf_wd = '1;
				sr_we = 1'b1;   sr_wa = clr_q[5:0];            sr_wd = '1;
				mir_we = 1'b1;  mir_wa = clr_q[6:0];           mir_wd = '1;
				main_we = 1'b1; main_wa = clr_q;
				spa_we = 1'b1;  spa_wa = clr_q[SAW-1:0];
			end
			fpb_pkg::ST_ACC: begin
				if (func_q[0] && slot) begin
					buf_we = is_buf;
					sr_we  = is_spr;
					mir_we = is_mir;
					if (func_q == fpb_pkg::F_WR_B) begin
						buf_wd = merged;
						sr_wd  = merged;
						mir_wd = merged;
					end
				end
			end
			fpb_pkg::ST_SWEEP: begin
				case (op_q)
					fpb_pkg::OP_LOAD: begin
						buf_we = v_s1;
						buf_wa = bufb_q + {5'b0, idx_s1[10:0]};
						buf_wd = lok_q ? main_rd : 16'hFFFF;
						sr_we  = v_s1 && (idx_s1 < fpb_pkg::LEN_SPARE[16:0]);
						sr_wa  = idx_s1[5:0];
						sr_wd  = lok_q ? spa_rd : 16'hFFFF;
					end
					fpb_pkg::OP_PROG: begin
						main_we = v_s1;
						main_wd = main_rd & buf_rd;
					end
					fpb_pkg::OP_PROG_SP: begin
						spa_we = v_s1;
						spa_wd = spa_rd & sr_rd;
					end
					default: begin
						main_we = v_s1;
						main_wa = {page_q[BW+5:6], idx_s1};
						spa_we  = v_s1 && (idx_s1 < fpb_pkg::LEN_BSPR[16:0]);
						spa_wa  = {page_q[BW+5:6], idx_s1[11:0]};
					end
				endcase
			end
			default: ;
		endcase
	end

	// control and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) areg_q[k] <= '0;
			bsel_q    <= fpb_pkg::BSEL_RST;
			sys_q     <= fpb_pkg::SYS_RST;
			stat_q    <= '0;
			irq_q     <= fpb_pkg::IRQ_RST;
			ufirst_q  <= '0;
			ulast_q   <= '0;
			lastcmd_q <= '0;
			open_q    <= '0;
			clr_q     <= '0;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			ov_q      <= 1'b0;
			op_q      <= fpb_pkg::OP_LOAD;
		end else begin
			if (state_q == fpb_pkg::ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			v_s1 <= issuing;
			if (issuing) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (reg_wr) begin
				if (a_q[11:5] == fpb_pkg::AREG_WIN) begin
					if (a_q[1:0] == 2'b00) begin
						areg_q[a_q[4:2]] <= wd_q;
					end
				end else begin
					case (a_q[11:0])
						fpb_pkg::R_BSEL:   bsel_q <= wd_q;
						fpb_pkg::R_SYSCFG: sys_q <= wd_q;
						fpb_pkg::R_IRQ:    irq_q <= irq_q & wd_q;
						fpb_pkg::R_UFIRST: ufirst_q <= wd_q;
						fpb_pkg::R_ULAST:  ulast_q <= wd_q;
						fpb_pkg::R_CMD: begin
							lastcmd_q <= cmd;
							stat_q    <= cmd_ok ? 16'h0000 : fpb_pkg::STAT_FAIL;
							irq_q     <= done_code;
							op_q      <= sweep_op;
							cnt_q     <= '0;
							if (cmd == fpb_pkg::C_UNLOCK && unl_ok) begin
								for (int k = 0; k < fpb_pkg::NUM_BLOCKS; k++) begin
									open_q[k] <= (16'(k) >= ufirst_q) && (16'(k) <= ulast_q);
								end
							end
						end
						default: ;
					endcase
				end
			end
			if (state_q == fpb_pkg::ST_DONE && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == fpb_pkg::ST_IDLE && req.valid) begin
			func_q <= req.func;
			a_q    <= req.offset[17:0];
			wd_q   <= req.wdata;
		end
		if (state_q == fpb_pkg::ST_ACC) begin
			res_rd_q  <= cmp_rd;
			res_flt_q <= cmp_flt;
			page_q    <= {areg_q[0][BW-1:0], areg_q[7][7:2]};
			bufb_q    <= (bsel_q[11:0] == fpb_pkg::BSEL_ALT) ? fpb_pkg::BUF_B : fpb_pkg::BUF_A;
			lok_q     <= blk_ex;
		end
		idx_s1 <= cnt_q[16:0];
		if (state_q == fpb_pkg::ST_DONE && (!ov_q || rsp.ready)) begin
			ord_q  <= res_rd_q;
			oflt_q <= res_flt_q;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.rdata = ord_q;
	assign rsp.fault = oflt_q;

	fpb_ram #(.W(16), .D(2 ** fpb_pkg::BUF_AW)) u_buf (
		.clk(clk), .we(buf_we), .waddr(buf_wa), .wdata(buf_wd), .raddr(buf_ra), .rdata(buf_rd)
	);
	fpb_ram #(.W(16), .D(2 ** fpb_pkg::SRAM_AW)) u_sram (
		.clk(clk), .we(sr_we), .waddr(sr_wa), .wdata(sr_wd), .raddr(sr_ra), .rdata(sr_rd)
	);
	fpb_ram #(.W(16), .D(2 ** fpb_pkg::MIR_AW)) u_mir (
		.clk(clk), .we(mir_we), .waddr(mir_wa), .wdata(mir_wd), .raddr(mir_ra), .rdata(mir_rd)
	);
	fpb_ram #(.W(16), .D(2 ** MAW)) u_main (
		.clk(clk), .we(main_we), .waddr(main_wa), .wdata(main_wd), .raddr(main_ra),
		.rdata(main_rd)
	);
	fpb_ram #(.W(16), .D(2 ** SAW)) u_spare (
		.clk(clk), .we(spa_we), .waddr(spa_wa), .wdata(spa_wd), .raddr(spa_ra), .rdata(spa_rd)
	);
endmodule
`default_nettype wire

// ===== rtl/fpb_checker.sv =====
// fpb_checker: port-level assertions for the flash page buffer device, with bind
`default_nettype none
module fpb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [15:0] rsp_rdata,
	input wire logic        rsp_fault
);
	logic [1:0] pend_q;
	logic       acc, dlv;

	assign acc = req_valid && req_ready;
	assign dlv = rsp_valid && rsp_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, acc} - {1'b0, dlv};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata) && $stable(rsp_fault))
		else $error("response changed while stalled");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fault |-> rsp_rdata == 16'h0000)
		else $error("faulted word carries data");
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without request");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !req_ready)
		else $error("too many words in flight");
endmodule

bind flash_page_buffer_device fpb_checker u_fpb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_rdata(rsp.rdata),
	.rsp_fault(rsp.fault)
);
`default_nettype wire
